// ===== rtl/udptpb_pkg.sv =====
package udptpb_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 512;
  localparam int unsigned MIN_FRAME_BYTES = 42;
  localparam int unsigned WORD_BYTES      = 8;

  localparam int unsigned LEN_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_FRAME_BYTES / 4);

  localparam logic [LEN_W-1:0] RESET_FRAME_LEN = LEN_W'(60);
  localparam logic [LEN_W-1:0] MIN_LEN         = LEN_W'(MIN_FRAME_BYTES);
  localparam logic [LEN_W-1:0] MAX_LEN         = LEN_W'(MAX_FRAME_BYTES);

  localparam logic [LEN_W-1:0] ETH_HDR_BYTES  = LEN_W'(14);
  localparam logic [LEN_W-1:0] ETH_IP_BYTES   = LEN_W'(34);
  localparam logic [LEN_W-1:0] ALL_HDR_BYTES  = LEN_W'(42);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_TOS         = 8'h10;
  localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
  localparam logic [7:0]  IP_TTL         = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] UDP_SRC_PORT   = 16'd2048;
  localparam logic [15:0] UDP_DST_PORT   = 16'd4096;

  // Index of the last 16-bit word fed to the adder in each header sum.
  localparam logic [IDX_W-1:0] IP_SUM_LAST  = IDX_W'(7);
  localparam logic [IDX_W-1:0] UDP_SUM_LAST = IDX_W'(8);

  // Frame word that carries the UDP checksum and the first payload bytes.
  localparam int unsigned FIRST_PAY_WORD = 5;

  // End-around ones-complement add of two 16-bit values.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

// ===== rtl/udp_test_packet_builder.sv =====
// One request (two MACs, two IPv4 addresses) yields one Ethernet/IPv4/UDP frame of
// frame_length bytes (42 to 512, clamped on write), sent as big-endian 64-bit words with the
// last word flagged and its byte count given. A single 16-bit end-around adder computes both
// checksums one word per cycle: 8 steps for the IP header, 9 for the UDP pseudo-header and
// header, and max(1, ceil((L-42)/4)) for the payload counters. The frame then streams out at
// one word per cycle while out_ready is high, ceil(L/8) words, and in_ready is high only
// between frames. frame_length is sampled when the request is accepted.
module udp_test_packet_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_source_mac,
  input  logic [47:0] in_dest_mac,
  input  logic [31:0] in_source_ip,
  input  logic [31:0] in_dest_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_frame_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last_word,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data
);

  localparam int unsigned LW = udptpb_pkg::LEN_W;
  localparam int unsigned IW = udptpb_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IP_SUM,
    S_UDP_SUM,
    S_PAY_SUM,
    S_EMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [LW-1:0]  len_cfg_r, len_cfg_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [47:0]    smac_r, smac_nxt, dmac_r, dmac_nxt;
  logic [31:0]    sip_r, sip_nxt, dip_r, dip_nxt;
  logic [15:0]    acc_r, acc_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [15:0]    ip_csum_r, ip_csum_nxt;
  logic [15:0]    udp_csum_r, udp_csum_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [63:0]    out_word_r, out_word_nxt;
  logic [3:0]     out_vb_r, out_vb_nxt;
  logic           out_last_r, out_last_nxt;

  logic [LW-1:0]  ip_len, udp_len, pay_len, pay_cnt, len_m1;
  logic [IW-1:0]  pay_last, last_widx;
  logic [3:0]     tail_bytes;
  logic [15:0]    operand, sum, csum_inv;
  logic [7:0]     cnt_lo, cnt_hi;
  logic [63:0]    raw_word, masked_word;
  logic           is_last;

  assign ip_len     = len_r - udptpb_pkg::ETH_HDR_BYTES;
  assign udp_len    = len_r - udptpb_pkg::ETH_IP_BYTES;
  assign pay_len    = len_r - udptpb_pkg::ALL_HDR_BYTES;
  assign pay_cnt    = (pay_len + LW'(3)) >> 2;
  assign pay_last   = (pay_cnt == '0) ? '0 : IW'(pay_cnt - LW'(1));
  assign len_m1     = len_r - LW'(1);
  assign last_widx  = IW'(len_m1 >> 3);
  assign tail_bytes = {1'b0, len_m1[2:0]} + 4'd1;

  // Operand sequence for the shared adder; zero fields of the headers are skipped.
  always_comb begin
    operand = '0;
    case (state_r)
      S_IP_SUM: begin
        case (idx_r)
          IW'(0):  operand = {udptpb_pkg::IP_VER_IHL, udptpb_pkg::IP_TOS};
          IW'(1):  operand = 16'(ip_len);
          IW'(2):  operand = udptpb_pkg::IP_FLAGS_DF;
          IW'(3):  operand = {udptpb_pkg::IP_TTL, udptpb_pkg::IP_PROTO_UDP};
          IW'(4):  operand = sip_r[31:16];
          IW'(5):  operand = sip_r[15:0];
          IW'(6):  operand = dip_r[31:16];
          default: operand = dip_r[15:0];
        endcase
      end
      S_UDP_SUM: begin
        case (idx_r)
          IW'(0):  operand = {8'h00, udptpb_pkg::IP_PROTO_UDP};
          IW'(1):  operand = sip_r[31:16];
          IW'(2):  operand = sip_r[15:0];
          IW'(3):  operand = dip_r[31:16];
          IW'(4):  operand = dip_r[15:0];
          IW'(5):  operand = udptpb_pkg::UDP_SRC_PORT;
          IW'(6):  operand = udptpb_pkg::UDP_DST_PORT;
          default: operand = 16'(udp_len);
        endcase
      end
      // Counters stay below 256, so each one adds only its low byte in the upper lane.
      S_PAY_SUM: operand = 16'({idx_r, 8'h00});
      default:   operand = '0;
    endcase
  end

  assign sum      = udptpb_pkg::ones_add(acc_r, operand);
  assign csum_inv = ~sum;

  // Payload words hold two counter low bytes at byte lanes two and six.
  assign cnt_lo = 8'({idx_r, 1'b0}) - 8'(2 * udptpb_pkg::FIRST_PAY_WORD);
  assign cnt_hi = cnt_lo + 8'd1;
  assign is_last = (idx_r == last_widx);

  always_comb begin
    case (idx_r)
      IW'(0):  raw_word = {dmac_r, smac_r[47:32]};
      IW'(1):  raw_word = {smac_r[31:0], udptpb_pkg::ETHERTYPE_IPV4,
                           udptpb_pkg::IP_VER_IHL, udptpb_pkg::IP_TOS};
      IW'(2):  raw_word = {16'(ip_len), 16'h0000, udptpb_pkg::IP_FLAGS_DF,
                           udptpb_pkg::IP_TTL, udptpb_pkg::IP_PROTO_UDP};
      IW'(3):  raw_word = {ip_csum_r, sip_r, dip_r[31:16]};
      IW'(4):  raw_word = {dip_r[15:0], udptpb_pkg::UDP_SRC_PORT,
                           udptpb_pkg::UDP_DST_PORT, 16'(udp_len)};
      IW'(udptpb_pkg::FIRST_PAY_WORD):
               raw_word = {udp_csum_r, cnt_lo, 24'h000000, cnt_hi, 8'h00};
      default: raw_word = {16'h0000, cnt_lo, 24'h000000, cnt_hi, 8'h00};
    endcase
  end

  always_comb begin
    masked_word = raw_word;
    for (int b = 0; b < int'(udptpb_pkg::WORD_BYTES); b++) begin
      if (is_last && (4'(b) >= tail_bytes)) begin
        masked_word[63 - 8*b -: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_cfg_nxt   = len_cfg_r;
    len_nxt       = len_r;
    smac_nxt      = smac_r;
    dmac_nxt      = dmac_r;
    sip_nxt       = sip_r;
    dip_nxt       = dip_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    ip_csum_nxt   = ip_csum_r;
    udp_csum_nxt  = udp_csum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_vb_nxt    = out_vb_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr_en) begin
      if (cfg_wr_data < udptpb_pkg::MIN_LEN) begin
        len_cfg_nxt = udptpb_pkg::MIN_LEN;
      end else if (cfg_wr_data > udptpb_pkg::MAX_LEN) begin
        len_cfg_nxt = udptpb_pkg::MAX_LEN;
      end else begin
        len_cfg_nxt = cfg_wr_data;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          smac_nxt  = in_source_mac;
          dmac_nxt  = in_dest_mac;
          sip_nxt   = in_source_ip;
          dip_nxt   = in_dest_ip;
          len_nxt   = len_cfg_r;
          acc_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_IP_SUM;
        end
      end
      S_IP_SUM: begin
        acc_nxt = sum;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == udptpb_pkg::IP_SUM_LAST) begin
          ip_csum_nxt = csum_inv;
          acc_nxt     = '0;
          idx_nxt     = '0;
          state_nxt   = S_UDP_SUM;
        end
      end
      S_UDP_SUM: begin
        acc_nxt = sum;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == udptpb_pkg::UDP_SUM_LAST) begin
          idx_nxt   = '0;
          state_nxt = S_PAY_SUM;
        end
      end
      S_PAY_SUM: begin
        // Counter zero adds nothing, so a frame without payload still takes one pass here.
        acc_nxt = sum;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == pay_last) begin
          udp_csum_nxt = (csum_inv == 16'h0000) ? 16'hFFFF : csum_inv;
          idx_nxt      = '0;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = masked_word;
          out_vb_nxt    = is_last ? tail_bytes : 4'd8;
          out_last_nxt  = is_last;
          idx_nxt       = idx_r + IW'(1);
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_cfg_r   <= udptpb_pkg::RESET_FRAME_LEN;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      len_cfg_r   <= len_cfg_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    smac_r     <= smac_nxt;
    dmac_r     <= dmac_nxt;
    sip_r      <= sip_nxt;
    dip_r      <= dip_nxt;
    acc_r      <= acc_nxt;
    ip_csum_r  <= ip_csum_nxt;
    udp_csum_r <= udp_csum_nxt;
    out_word_r <= out_word_nxt;
    out_vb_r   <= out_vb_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_frame_word  = out_word_r;
  assign out_valid_bytes = out_vb_r;
  assign out_last_word   = out_last_r;

endmodule
